// ----- rtl/core/ansf_pkg.sv -----
// Shared constants and types for the SGR-only escape sequence filter.
`timescale 1ns / 1ps

package ansf_pkg;

    localparam int SEQ_DEPTH_DEF = 32;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_OPEN = 8'h5B;
    localparam logic [7:0] CH_SGR  = 8'h6D;   // 'm'
    localparam logic [7:0] CH_L    = 8'h6C;   // 'l'
    localparam logic [7:0] CH_H    = 8'h68;   // 'h'
    localparam logic [7:0] CH_R    = 8'h72;   // 'r'
    localparam logic [7:0] CH_N    = 8'h6E;   // 'n'

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_SEQ  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_PEND   = 2'd1,
        ST_REPLAY = 2'd2
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
        logic       dropped;
    } t_result;

    function automatic logic is_term(input logic [7:0] b);
        return (b == CH_SGR) || (b == CH_L) || (b == CH_H) || (b == CH_R) || (b == CH_N);
    endfunction

endpackage

// ----- rtl/core/ansi_sgr_only_filter.sv -----
// Top level: SGR-only control sequence filter with a sequence buffer memory.
// Results are registered; a transfer's first result shows in the cycle after it.
// Throughput: plain bytes one per cycle while the master is ready; ESC then a byte other
// than '[' or ESC gives two results; a kept color sequence replays one byte per cycle
// from the buffer memory; input waits until the last result of either is registered.
// Reset: synchronous active low; clears parse state and output valid, not the buffer.
`timescale 1ns / 1ps

module ansi_sgr_only_filter #(
    parameter int SEQ_DEPTH = ansf_pkg::SEQ_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,    // stream_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic       o_m_tlast,    // run_last
    output logic [2:0] o_m_tuser     // [0] byte_valid, [1] stream_end, [2] seq_dropped_long
);
    import ansf_pkg::*;

    localparam int AW = $clog2(SEQ_DEPTH);
    localparam logic [AW-1:0] CNT_MAX  = AW'(SEQ_DEPTH - 1);
    localparam logic [AW-1:0] IDX_OPEN = AW'(1);
    localparam logic [AW-1:0] CNT_HDR  = AW'(2);

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [AW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_end, n_end;
    logic [7:0]    r_pend, n_pend;
    t_result       r_out, n_out;
    logic          r_out_valid, n_out_valid;
    logic          wr_en;
    logic          slot_free;
    logic          s_acc;

    logic [7:0]    r_mem [SEQ_DEPTH];
    logic [7:0]    r_rdata;

    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && slot_free;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.out_byte;
    assign o_m_tlast  = r_out.run_last;
    assign o_m_tuser  = {r_out.dropped, r_out.stream_end, r_out.byte_valid};

    always_comb begin
        t_result    a0;
        logic       have0;
        logic       have1;
        logic       go_rep;
        logic [7:0] b;
        logic       last;

        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_end       = r_end;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        wr_en       = 1'b0;
        a0          = '0;
        have0       = 1'b0;
        have1       = 1'b0;
        go_rep      = 1'b0;
        b           = i_s_tdata;
        last        = i_s_tlast;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (r_mode)
                        MODE_ESC: begin
                            if (b == CH_OPEN) begin
                                n_count = CNT_HDR;
                                n_ovf   = 1'b0;
                                n_mode  = MODE_SEQ;
                            end else begin
                                a0    = '{out_byte: CH_ESC, byte_valid: 1'b1, default: 1'b0};
                                have0 = 1'b1;
                                if (b == CH_ESC) begin
                                    n_mode = MODE_ESC;
                                    if (last) begin
                                        have1  = 1'b1;
                                        n_pend = CH_ESC;
                                    end
                                end else begin
                                    n_mode = MODE_TEXT;
                                    have1  = 1'b1;
                                    n_pend = b;
                                end
                            end
                        end
                        MODE_SEQ: begin
                            if (is_term(b)) begin
                                n_mode = MODE_TEXT;
                                n_ovf  = 1'b0;
                                if (b == CH_SGR && r_ovf) begin
                                    a0 = '{out_byte: 8'h00, dropped: 1'b1, default: 1'b0};
                                    have0   = 1'b1;
                                    n_count = '0;
                                end else if (b == CH_SGR) begin
                                    go_rep = 1'b1;
                                end else begin
                                    n_count = '0;
                                end
                            end else if (!r_ovf && r_count < CNT_MAX) begin
                                wr_en   = 1'b1;
                                n_count = r_count + AW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        default: begin
                            if (b == CH_ESC) begin
                                n_mode = MODE_ESC;
                                if (last) begin
                                    a0    = '{out_byte: CH_ESC, byte_valid: 1'b1, default: 1'b0};
                                    have0 = 1'b1;
                                end
                            end else begin
                                n_mode = MODE_TEXT;
                                a0     = '{out_byte: b, byte_valid: 1'b1, default: 1'b0};
                                have0  = 1'b1;
                            end
                        end
                    endcase

                    if (last) begin
                        n_mode = MODE_TEXT;
                        n_ovf  = 1'b0;
                        if (!go_rep) begin
                            n_count = '0;
                        end
                        if (!have0 && !go_rep) begin
                            a0    = '0;
                            have0 = 1'b1;
                        end
                    end

                    n_end = last;
                    if (go_rep) begin
                        n_out       = '{out_byte: CH_ESC, byte_valid: 1'b1, default: 1'b0};
                        n_out_valid = 1'b1;
                        n_idx       = IDX_OPEN;
                        n_state     = ST_REPLAY;
                    end else if (have1) begin
                        n_out       = a0;
                        n_out_valid = 1'b1;
                        n_state     = ST_PEND;
                    end else if (have0) begin
                        n_out            = a0;
                        n_out.run_last   = 1'b1;
                        n_out.stream_end = last;
                        n_out_valid      = 1'b1;
                    end
                end
            end
            ST_PEND: begin
                if (slot_free) begin
                    n_out = '{out_byte: r_pend, byte_valid: 1'b1, run_last: 1'b1,
                              stream_end: r_end, dropped: 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_REPLAY: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_idx == r_count) begin
                        n_out = '{out_byte: CH_SGR, byte_valid: 1'b1, run_last: 1'b1,
                                  stream_end: r_end, dropped: 1'b0};
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        if (r_idx == IDX_OPEN) begin
                            n_out = '{out_byte: CH_OPEN, byte_valid: 1'b1, default: 1'b0};
                        end else begin
                            n_out = '{out_byte: r_rdata, byte_valid: 1'b1, default: 1'b0};
                        end
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_TEXT;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end  <= n_end;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // buffer: write at fill position, read one ahead of the replay index
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count] <= i_s_tdata;
        end
        r_rdata <= r_mem[n_idx];
    end

endmodule

// ----- rtl/core/ansf_chk.sv -----
// Port-level checker for the SGR-only filter, bound to the top level.
`timescale 1ns / 1ps

module ansf_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic [2:0] o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("master transfer changed while stalled");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 8'h00)
        else $error("marker result carries a nonzero byte");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast)
        else $error("stream end without run last");

    a_drop_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> !o_m_tuser[0] && o_m_tlast)
        else $error("dropped flag on a data result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind ansi_sgr_only_filter ansf_chk u_ansf_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

// ----- verif/tb_ansi_sgr_only_filter.sv -----
// Self-checking testbench for the SGR-only control sequence filter.
`timescale 1ns / 1ps

module tb_ansi_sgr_only_filter;

    import ansf_pkg::*;

    localparam int SEQ_DEPTH   = SEQ_DEPTH_DEF;
    localparam int LONG_HOLD   = 400;
    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
        logic       long_drop;
    } filt_result_t;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_s_tlast  = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic [2:0] o_m_tuser;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int last_pct      = 0;
    int items_sent    = 0;
    int err_count     = 0;
    int rx_hold_reqs  = 0;
    int rx_hold_seen  = 0;
    int rx_hold_left  = 0;

    filt_result_t filtered_q[$];
    filt_result_t step_out[$];

    t_mode      p_mode = MODE_TEXT;
    logic [7:0] p_buf [SEQ_DEPTH];
    int         p_count = 0;
    logic       p_ovf = 1'b0;

    ansi_sgr_only_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic ends_seq(input logic [7:0] b);
        return (b == CH_SGR) | (b == CH_L) | (b == CH_H) | (b == CH_R) | (b == CH_N);
    endfunction

    function automatic void push_out(input logic [7:0] b, input logic v, input logic d);
        filt_result_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.run_last   = 1'b0;
        r.stream_end = 1'b0;
        r.long_drop  = d;
        step_out.push_back(r);
    endfunction

    function automatic void text_in(input logic [7:0] b);
        if (b == CH_ESC) begin
            p_mode = MODE_ESC;
        end else begin
            push_out(b, 1'b1, 1'b0);
        end
    endfunction

    function automatic void clear_parse();
        p_mode  = MODE_TEXT;
        p_count = 0;
        p_ovf   = 1'b0;
    endfunction

    // Expected results of one accepted byte, appended to filtered_q.
    function automatic void filter_step(input logic [7:0] b, input logic last);
        filt_result_t r;
        int n;
        step_out.delete();
        case (p_mode)
            MODE_ESC: begin
                if (b == CH_OPEN) begin
                    p_buf[0] = CH_ESC;
                    p_buf[1] = CH_OPEN;
                    p_count  = 2;
                    p_ovf    = 1'b0;
                    p_mode   = MODE_SEQ;
                end else begin
                    push_out(CH_ESC, 1'b1, 1'b0);
                    p_mode = MODE_TEXT;
                    text_in(b);
                end
            end
            MODE_SEQ: begin
                if (ends_seq(b)) begin
                    if (b == CH_SGR) begin
                        if (p_ovf) begin
                            push_out(8'h00, 1'b0, 1'b1);
                        end else begin
                            for (int k = 0; k < p_count; k++) push_out(p_buf[k], 1'b1, 1'b0);
                            push_out(b, 1'b1, 1'b0);
                        end
                    end
                    clear_parse();
                end else if (!p_ovf && p_count < SEQ_DEPTH - 1) begin
                    p_buf[p_count] = b;
                    p_count++;
                end else begin
                    p_ovf = 1'b1;
                end
            end
            default: begin
                p_mode = MODE_TEXT;
                text_in(b);
            end
        endcase
        if (last) begin
            if (p_mode == MODE_ESC) push_out(CH_ESC, 1'b1, 1'b0);
            clear_parse();
            if (step_out.size() == 0) push_out(8'h00, 1'b0, 1'b0);
            n = step_out.size();
            r = step_out[n-1];
            r.stream_end = 1'b1;
            step_out[n-1] = r;
        end
        n = step_out.size();
        if (n > 0) begin
            r = step_out[n-1];
            r.run_last = 1'b1;
            step_out[n-1] = r;
        end
        foreach (step_out[i]) filtered_q.push_back(step_out[i]);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_LIMIT)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Input monitor and output checker share one process.
    always @(posedge i_clk) begin : monitor
        filt_result_t want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) filter_step(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("result with none pending", o_m_tdata, -1);
                end else begin
                    want = filtered_q.pop_front();
                    if (o_m_tdata !== want.out_byte)
                        report_mismatch("out_byte", o_m_tdata, want.out_byte);
                    if (o_m_tuser[0] !== want.byte_valid)
                        report_mismatch("byte_valid", o_m_tuser[0], want.byte_valid);
                    if (o_m_tlast !== want.run_last)
                        report_mismatch("run_last", o_m_tlast, want.run_last);
                    if (o_m_tuser[1] !== want.stream_end)
                        report_mismatch("stream_end", o_m_tuser[1], want.stream_end);
                    if (o_m_tuser[2] !== want.long_drop)
                        report_mismatch("seq_dropped_long", o_m_tuser[2], want.long_drop);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (rx_hold_reqs != rx_hold_seen) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic rnd_last();
        return ($urandom_range(99) < last_pct);
    endfunction

    function automatic logic [7:0] param_byte();
        logic [7:0] b;
        if ($urandom_range(99) < 80) begin
            b = (($urandom_range(10) == 10) ? 8'h3B : 8'h30 + 8'($urandom_range(9)));
        end else begin
            b = 8'($urandom_range(255));
            while (ends_seq(b)) b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic logic [7:0] rand_term();
        case ($urandom_range(9))
            0: return CH_L;
            1: return CH_H;
            2: return CH_R;
            3: return CH_N;
            default: return CH_SGR;
        endcase
    endfunction

    task automatic send_seq(input int n_params, input logic [7:0] term);
        send_byte(CH_ESC, rnd_last());
        send_byte(CH_OPEN, rnd_last());
        for (int k = 0; k < n_params; k++) send_byte(param_byte(), rnd_last());
        send_byte(term, rnd_last());
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        last_pct     = 0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // lone ESC, then ESC ESC '[' 'm'
        send_byte(CH_ESC, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_OPEN, 1'b0);
        send_byte(CH_SGR, 1'b0);
        send_seq(0, CH_L);
        send_seq(0, CH_H);
        send_seq(0, CH_R);
        send_seq(0, CH_N);
        // ESC inside a sequence is held like any other byte
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_OPEN, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_SGR, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(CH_ESC, 1'b1);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_OPEN, 1'b1);
        wait_drained();
    endtask

    task automatic test_seq_length();
        tx_idle_pct  = 35;
        rx_stall_pct = 35;
        last_pct     = 0;
        send_seq(0, CH_SGR);
        send_seq(SEQ_DEPTH - 3, CH_SGR);
        send_seq(SEQ_DEPTH - 2, CH_SGR);
        send_seq(2, CH_SGR);
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        last_pct     = 0;
        rx_hold_reqs++;
        send_seq(10, CH_SGR);
        for (int k = 0; k < 6; k++) send_byte(8'($urandom_range(255)) & 8'h7F | 8'h20, 1'b0);
        send_seq(6, CH_SGR);
        // pause until everything has come out
        wait_drained();
        send_seq(4, CH_SGR);
        send_byte(8'h5A, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int n_items);
        int stop_at;
        int pick;
        int n;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        last_pct     = 3;
        stop_at      = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_seq($urandom_range(8), rand_term());
            end else if (pick < 65) begin
                send_seq($urandom_range(SEQ_DEPTH + 2, SEQ_DEPTH - 6), rand_term());
            end else if (pick < 75) begin
                send_byte(CH_ESC, rnd_last());
                send_byte(8'($urandom_range(255)), rnd_last());
            end else if (pick < 80) begin
                // sequence cut short by end of stream
                send_byte(CH_ESC, 1'b0);
                send_byte(CH_OPEN, 1'b0);
                n = $urandom_range(4);
                for (int k = 0; k < n; k++) send_byte(param_byte(), 1'b0);
                send_byte(param_byte(), 1'b1);
            end else begin
                n = $urandom_range(4, 1);
                for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)), rnd_last());
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_directed();
        test_seq_length();
        test_backpressure();
        test_random(0, 0, 15);
        test_random(76, 0, 15);
        test_random(0, 76, 15);
        test_random(35, 35, 15);
        wait_drained();
        if (err_count == 0 && filtered_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- ansi_sgr_only_filter.f -----
rtl/core/ansf_pkg.sv
rtl/core/ansi_sgr_only_filter.sv
rtl/core/ansf_chk.sv
verif/tb_ansi_sgr_only_filter.sv
